// ===== rtl/core/rsc_pkg.sv =====
// Shared types, codes and constants of the radar sweep return colouriser.
package rsc_pkg;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_ADVANCE = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_COLUMN_COUNT  = 3'd0;
	localparam logic [2:0] REG_ROW_COUNT     = 3'd1;
	localparam logic [2:0] REG_LEFT_LIMIT    = 3'd2;
	localparam logic [2:0] REG_RIGHT_LIMIT   = 3'd3;
	localparam logic [2:0] REG_ENERGY_SCALE  = 3'd4;
	localparam logic [2:0] REG_SHADOW_ENABLE = 3'd5;

	// Result kinds.
	localparam logic KIND_ANTENNA = 1'b0;
	localparam logic KIND_PIXEL   = 1'b1;

	// Precipitation levels.
	localparam logic [2:0] LEVEL_BLACK   = 3'd0;
	localparam logic [2:0] LEVEL_GREEN   = 3'd1;
	localparam logic [2:0] LEVEL_YELLOW  = 3'd2;
	localparam logic [2:0] LEVEL_RED     = 3'd3;
	localparam logic [2:0] LEVEL_MAGENTA = 3'd4;
	localparam logic [2:0] LEVEL_SHADOW  = 3'd5;

	// ARGB colours.
	localparam logic [31:0] COLOUR_SHADOW  = 32'hff505050;
	localparam logic [31:0] COLOUR_MAGENTA = 32'hffa564d8;
	localparam logic [31:0] COLOUR_RED     = 32'hff2420ed;
	localparam logic [31:0] COLOUR_YELLOW  = 32'hff00f2ff;
	localparam logic [31:0] COLOUR_GREEN   = 32'hff55c278;
	localparam logic [31:0] COLOUR_BLACK   = 32'hff000000;

	// Level thresholds in Q17.40, rounded up, for energy times scale.
	localparam logic [56:0] TH_MAGENTA = 57'd13194139534;
	localparam logic [56:0] TH_RED     = 57'd9895604650;
	localparam logic [56:0] TH_YELLOW  = 57'd6597069767;
	localparam logic [56:0] TH_GREEN   = 57'd4947802325;

	// Running energy: 0.8 in Q2.24 and the saturation ceiling.
	localparam logic [25:0] SHADOW_LIMIT = 26'd13421772;
	localparam logic [25:0] SUM_MAX      = 26'h3ffffff;

	typedef struct packed {
		logic [10:0] column_count;
		logic [10:0] row_count;
		logic [9:0]  left_limit;
		logic [9:0]  right_limit;
		logic [31:0] energy_scale;
		logic        shadow_enable;
	} cfg_t;

	// Item after the sweep stage.
	typedef struct packed {
		logic        kind;
		logic [9:0]  column;
		logic [10:0] index;
		logic [24:0] energy;
		logic        pixel;
		logic        overrun;
		logic        line_last;
		logic        shadow;
	} sweep_item_t;

	// Item after the partial-product stage.
	typedef struct packed {
		logic        kind;
		logic [9:0]  column;
		logic [19:0] pixel_addr;
		logic [47:0] prod_lo;
		logic [40:0] prod_hi;
		logic        pixel;
		logic        overrun;
		logic        line_last;
		logic        shadow;
	} mult_item_t;

	typedef struct packed {
		logic        kind;
		logic [9:0]  column;
		logic [19:0] pixel_addr;
		logic [31:0] colour;
		logic [2:0]  level;
		logic        pixel_valid;
		logic        overrun;
		logic        line_last;
	} result_t;

endpackage

// ===== rtl/core/rsc_if.sv =====
// Handshake interfaces for the command, result and configuration channels.
interface rsc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [24:0] energy;

	modport source (output valid, output func, output energy, input ready);
	modport sink (input valid, input func, input energy, output ready);
endinterface

interface rsc_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [9:0]  column;
	logic [19:0] pixel_addr;
	logic [31:0] colour;
	logic [2:0]  level;
	logic        pixel_valid;
	logic        overrun;
	logic        line_last;

	modport source (output valid, output kind, output column, output pixel_addr,
		output colour, output level, output pixel_valid, output overrun,
		output line_last, input ready);
	modport sink (input valid, input kind, input column, input pixel_addr,
		input colour, input level, input pixel_valid, input overrun,
		input line_last, output ready);
endinterface

interface rsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rsc_cfg.sv =====
// Configuration register bank of the colouriser.
module rsc_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [31:0]   wr_data,
	output rsc_pkg::cfg_t cfg
);
	import rsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_count  <= 11'd512;
			cfg_q.row_count     <= 11'd512;
			cfg_q.left_limit    <= 10'd0;
			cfg_q.right_limit   <= 10'd511;
			cfg_q.energy_scale  <= 32'd65536;
			cfg_q.shadow_enable <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_COLUMN_COUNT:  cfg_q.column_count  <= wr_data[10:0];
				REG_ROW_COUNT:     cfg_q.row_count     <= wr_data[10:0];
				REG_LEFT_LIMIT:    cfg_q.left_limit    <= wr_data[9:0];
				REG_RIGHT_LIMIT:   cfg_q.right_limit   <= wr_data[9:0];
				REG_ENERGY_SCALE:  cfg_q.energy_scale  <= wr_data;
				REG_SHADOW_ENABLE: cfg_q.shadow_enable <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== rtl/core/rsc_sweep.sv =====
// Antenna sweep, scan line state and first pipeline stage.
module rsc_sweep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 advance,
	input  logic [1:0]           func,
	input  logic [24:0]          energy,
	input  logic [9:0]           edge_col,
	input  logic [10:0]          rows,
	input  logic [9:0]           left_limit,
	input  logic [9:0]           right_limit,
	input  logic                 shadow_enable,
	output logic                 item_valid,
	output rsc_pkg::sweep_item_t item
);
	import rsc_pkg::*;

	logic [9:0]  column_q;
	logic        rightward_q;
	logic [10:0] index_q;
	logic [25:0] sum_q;

	logic [9:0]  column_nx;
	logic        rightward_nx;
	logic [10:0] index_nx;
	logic [25:0] sum_nx;
	logic [26:0] sum_wide;
	logic [10:0] centre;
	logic        item_nx_valid;
	sweep_item_t item_nx;

	logic        valid_s1;
	sweep_item_t item_s1;

	always_comb begin
		column_nx     = column_q;
		rightward_nx  = rightward_q;
		index_nx      = index_q;
		sum_nx        = sum_q;
		sum_wide      = {1'b0, sum_q} + {2'b00, energy};
		centre        = ({1'b0, edge_col} + 11'd1) >> 1;
		item_nx_valid = 1'b0;
		item_nx       = '0;
		case (func)
			FUNC_ADVANCE: begin
				if (rightward_q) begin
					column_nx = (column_q >= edge_col) ? edge_col : column_q + 10'd1;
					if (column_nx >= edge_col || column_nx == right_limit)
						rightward_nx = 1'b0;
				end else begin
					column_nx = (column_q == 10'd0) ? 10'd0 : column_q - 10'd1;
					if (column_nx == 10'd0 || column_nx == left_limit)
						rightward_nx = 1'b1;
				end
				index_nx       = '0;
				sum_nx         = '0;
				item_nx_valid  = 1'b1;
				item_nx.kind   = KIND_ANTENNA;
				item_nx.column = column_nx;
			end
			FUNC_RESTART: begin
				column_nx      = centre[9:0];
				index_nx       = '0;
				sum_nx         = '0;
				item_nx_valid  = 1'b1;
				item_nx.kind   = KIND_ANTENNA;
				item_nx.column = column_nx;
			end
			FUNC_SAMPLE: begin
				item_nx_valid  = 1'b1;
				item_nx.kind   = KIND_PIXEL;
				item_nx.column = column_q;
				item_nx.index  = index_q;
				item_nx.energy = energy;
				if (index_q >= rows) begin
					item_nx.overrun = 1'b1;
				end else begin
					sum_nx = sum_wide[26] ? SUM_MAX : sum_wide[25:0];
					index_nx = index_q + 11'd1;
					item_nx.pixel = 1'b1;
					item_nx.line_last = ({1'b0, index_q} + 12'd1) == {1'b0, rows};
					item_nx.shadow = shadow_enable && (sum_nx > SHADOW_LIMIT);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= 10'd256;
			rightward_q <= 1'b0;
			index_q     <= '0;
			sum_q       <= '0;
		end else if (accept) begin
			column_q    <= column_nx;
			rightward_q <= rightward_nx;
			index_q     <= index_nx;
			sum_q       <= sum_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && item_nx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			item_s1 <= item_nx;
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;
endmodule

// ===== rtl/core/rsc_colour.sv =====
// Energy scaling, pixel addressing and colour selection stages.
module rsc_colour (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 item_valid,
	input  rsc_pkg::sweep_item_t item,
	input  logic [10:0]          rows,
	input  logic [31:0]          energy_scale,
	output logic                 res_valid,
	output rsc_pkg::result_t     res
);
	import rsc_pkg::*;

	mult_item_t mult_nx;
	logic [20:0] line_base;
	logic [21:0] addr_wide;

	logic       valid_s2;
	mult_item_t item_s2;

	logic [56:0] prod;
	result_t     res_nx;

	logic    valid_s3;
	result_t res_s3;

	// The 25 by 32 product is split at bit 16 of the energy into two
	// partial products, summed in the next stage.
	always_comb begin
		line_base          = {10'b0, item.column} * {10'b0, rows};
		addr_wide          = {1'b0, line_base} + {11'b0, item.index};
		mult_nx.kind       = item.kind;
		mult_nx.column     = item.column;
		mult_nx.pixel_addr = addr_wide[19:0];
		mult_nx.prod_lo    = {32'b0, item.energy[15:0]} * {16'b0, energy_scale};
		mult_nx.prod_hi    = {32'b0, item.energy[24:16]} * {9'b0, energy_scale};
		mult_nx.pixel      = item.pixel;
		mult_nx.overrun    = item.overrun;
		mult_nx.line_last  = item.line_last;
		mult_nx.shadow     = item.shadow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= item_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= mult_nx;
			res_s3  <= res_nx;
		end
	end

	always_comb begin
		prod = {9'b0, item_s2.prod_lo} + {item_s2.prod_hi, 16'b0};
		res_nx = '0;
		res_nx.kind    = item_s2.kind;
		res_nx.column  = item_s2.column;
		res_nx.overrun = item_s2.overrun;
		if (item_s2.pixel) begin
			res_nx.pixel_valid = 1'b1;
			res_nx.pixel_addr  = item_s2.pixel_addr;
			res_nx.line_last   = item_s2.line_last;
			if (item_s2.shadow) begin
				res_nx.colour = COLOUR_SHADOW;
				res_nx.level  = LEVEL_SHADOW;
			end else if (prod >= TH_MAGENTA) begin
				res_nx.colour = COLOUR_MAGENTA;
				res_nx.level  = LEVEL_MAGENTA;
			end else if (prod >= TH_RED) begin
				res_nx.colour = COLOUR_RED;
				res_nx.level  = LEVEL_RED;
			end else if (prod >= TH_YELLOW) begin
				res_nx.colour = COLOUR_YELLOW;
				res_nx.level  = LEVEL_YELLOW;
			end else if (prod >= TH_GREEN) begin
				res_nx.colour = COLOUR_GREEN;
				res_nx.level  = LEVEL_GREEN;
			end else begin
				res_nx.colour = COLOUR_BLACK;
				res_nx.level  = LEVEL_BLACK;
			end
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;
endmodule

// ===== rtl/core/radar_sweep_return_colouriser.sv =====
// Top level of the radar sweep return colouriser.
// The block takes one command transfer in every clock cycle that is not
// stalled and gives one result transfer for each advance, sample or
// restart command (an unused func code is dropped without a result). It
// has three registered stages: the sweep stage updates the antenna column,
// sample index and running energy as the command is taken; the second stage
// forms the pixel address and the two partial products of energy times
// scale; the third sums them, compares with the level thresholds and
// registers the colour. All three stages move together and halt only while
// a result is held at the output, so the command channel is ready whenever
// the result channel is ready or empty. Configuration writes are always
// accepted and should be made only while no command is in flight.
module radar_sweep_return_colouriser #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input logic      clk,
	input logic      arst_n,
	rsc_cmd_if.sink  cmd,
	rsc_rsp_if.source rsp,
	rsc_cfg_if.sink  cfg
);
	import rsc_pkg::*;

	cfg_t        cfg_regs;
	logic        advance;
	logic        accept;
	logic [9:0]  edge_col;
	logic [10:0] rows;
	int          col_clamped;
	logic        item_valid;
	sweep_item_t item;
	logic        res_valid;
	result_t     res;

	// The pipeline stalls only while a finished result waits to be taken.
	assign advance   = !(rsp.valid && !rsp.ready);
	assign cmd.ready = advance;
	assign accept    = cmd.valid && advance;
	assign cfg.ready = 1'b1;

	// Right edge of the screen: the column count held between two and the
	// column limit, less one, never beyond the widest column code.
	always_comb begin
		col_clamped = int'(cfg_regs.column_count);
		if (col_clamped < 2)
			col_clamped = 2;
		if (col_clamped > MAX_COLUMNS)
			col_clamped = MAX_COLUMNS;
		col_clamped = col_clamped - 1;
		if (col_clamped > 1023)
			col_clamped = 1023;
		edge_col = col_clamped[9:0];
	end

	// Rows per scan line, held to the row limit. A row count of zero turns
	// every sample into an overrun.
	assign rows = (int'(cfg_regs.row_count) > MAX_ROWS) ? 11'(MAX_ROWS)
		: cfg_regs.row_count;

	rsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	rsc_sweep u_sweep (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.advance       (advance),
		.func          (cmd.func),
		.energy        (cmd.energy),
		.edge_col      (edge_col),
		.rows          (rows),
		.left_limit    (cfg_regs.left_limit),
		.right_limit   (cfg_regs.right_limit),
		.shadow_enable (cfg_regs.shadow_enable),
		.item_valid    (item_valid),
		.item          (item)
	);

	rsc_colour u_colour (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item_valid   (item_valid),
		.item         (item),
		.rows         (rows),
		.energy_scale (cfg_regs.energy_scale),
		.res_valid    (res_valid),
		.res          (res)
	);

	assign rsp.valid       = res_valid;
	assign rsp.kind        = res.kind;
	assign rsp.column      = res.column;
	assign rsp.pixel_addr  = res.pixel_addr;
	assign rsp.colour      = res.colour;
	assign rsp.level       = res.level;
	assign rsp.pixel_valid = res.pixel_valid;
	assign rsp.overrun     = res.overrun;
	assign rsp.line_last   = res.line_last;
endmodule
